// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the brush blend block.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds -> b holds in the same cycle
`define RPBB_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a holds -> b holds in the next cycle
`define RPBB_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/rpbb_pkg.sv =====
// Types and constants of the radial pattern brush blend block.
// No dependencies; used by every module of the block.
package rpbb_pkg;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 21;

    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HARDNESS   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_RED   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_GREEN = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_BLUE  = 3'd6;

    localparam int D2_BITS    = 40;
    localparam int ROOT_BITS  = 31;
    localparam int QUOT_BITS  = 17;

    localparam logic [16:0] FULL_ONE  = 17'h10000;
    localparam logic [15:0] CH_MAX_Q8 = 16'hFF00;

    typedef struct packed {
        logic        in_circle;
        logic        mask;
        logic [23:0] dest;
        logic [23:0] pat;
    } rpbb_item_t;

    typedef struct packed {
        rpbb_item_t           item;
        logic [D2_BITS-1:0]   d2;
    } rpbb_entry_t;

    typedef struct packed {
        logic signed [20:0] center_x;
        logic signed [20:0] center_y;
        logic [39:0]        r2;
    } rpbb_front_cfg_t;

    typedef struct packed {
        logic [19:0] radius;
        logic [16:0] hardness;
        logic [15:0] gain_r;
        logic [15:0] gain_g;
        logic [15:0] gain_b;
    } rpbb_back_cfg_t;

endpackage

// ===== rtl/core/radial_pattern_brush_blend.sv =====
// Top level of the radial pattern brush blend: configuration registers,
// front end, queue and back end. Uses rpbb_pkg, assert_macros.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  input   | push / full          | pixel_x pixel_y dest_pixel pattern_pixel
//          |                      | mask_pass
//  result  | empty / pop          | write_enable new_pixel
//  config  | cfg_valid/cfg_ready  | cfg_index cfg_data
//
// One pixel per cycle sustained while results are popped; every transaction
// gives one result. Stages: 2 front stages, the queue, 31 square root stages
// (one root bit each), 17 divide stages (one quotient bit each), 2 blend
// stages and the output register.
// While a result waits, the back pipeline holds and the 4-entry queue plus
// front stages keep taking transactions until full. Reset clears all
// valid flags and loads the register reset values; no clearing pass.
module radial_pattern_brush_blend #(
    parameter int COORD_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [COORD_BITS-1:0]                 pixel_x,
    input  logic [COORD_BITS-1:0]                 pixel_y,
    input  logic [23:0]                           dest_pixel,
    input  logic [23:0]                           pattern_pixel,
    input  logic                                  mask_pass,
    output logic                                  empty,
    input  logic                                  pop,
    output logic                                  write_enable,
    output logic [23:0]                           new_pixel,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rpbb_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [rpbb_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import rpbb_pkg::*;
    `include "assert_macros.svh"

    logic signed [20:0] center_x_reg, center_y_reg;
    logic [19:0]        radius_reg;
    logic [16:0]        hardness_reg;
    logic [15:0]        gain_r_reg, gain_g_reg, gain_b_reg;
    logic [39:0]        r2_reg;
    logic [19:0]        r_eff;
    logic [16:0]        h_eff;

    rpbb_front_cfg_t front_cfg;
    rpbb_back_cfg_t  back_cfg;
    rpbb_entry_t     wr_entry, rd_entry;
    logic            q_push, q_full, q_pop, q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= 20'd2560;
            hardness_reg <= FULL_ONE;
            gain_r_reg   <= 16'd256;
            gain_g_reg   <= 16'd256;
            gain_b_reg   <= 16'd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CENTER_X:   center_x_reg <= cfg_data;
                REG_CENTER_Y:   center_y_reg <= cfg_data;
                REG_RADIUS:     radius_reg   <= cfg_data[19:0];
                REG_HARDNESS:   hardness_reg <= cfg_data[16:0];
                REG_GAIN_RED:   gain_r_reg   <= cfg_data[15:0];
                REG_GAIN_GREEN: gain_g_reg   <= cfg_data[15:0];
                REG_GAIN_BLUE:  gain_b_reg   <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    assign r_eff = (radius_reg == '0) ? 20'd1 : radius_reg;
    assign h_eff = (hardness_reg > FULL_ONE) ? FULL_ONE : hardness_reg;

    always_ff @(posedge clk)
    begin
        r2_reg <= 40'(r_eff) * 40'(r_eff);
    end

    assign front_cfg = '{center_x: center_x_reg, center_y: center_y_reg, r2: r2_reg};
    assign back_cfg  = '{radius: r_eff, hardness: h_eff, gain_r: gain_r_reg,
                         gain_g: gain_g_reg, gain_b: gain_b_reg};

    rpbb_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (front_cfg),
        .push         (push),
        .full         (full),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .dest_pixel   (dest_pixel),
        .pattern_pixel(pattern_pixel),
        .mask_pass    (mask_pass),
        .q_push       (q_push),
        .q_entry      (wr_entry),
        .q_full       (q_full)
    );

    rpbb_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_entry(wr_entry),
        .full    (q_full),
        .pop     (q_pop),
        .rd_entry(rd_entry),
        .empty   (q_empty)
    );

    rpbb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (back_cfg),
        .q_entry     (rd_entry),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .write_enable(write_enable),
        .new_pixel   (new_pixel)
    );

    `RPBB_ASSERT_IMP(a_queue_room, q_push, !q_full)
    `RPBB_ASSERT_IMP(a_queue_data, q_pop, !q_empty)
    `RPBB_ASSERT_IMP(a_full_from_queue, full, q_full)

endmodule

// ===== rtl/core/rpbb_front.sv =====
// Front end: takes pixel transactions, forms squared distance, classifies
// inside/outside the brush circle and pushes into the queue. Uses rpbb_pkg.
module rpbb_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rpbb_pkg::rpbb_front_cfg_t cfg,
    input  logic                     push,
    output logic                     full,
    input  logic [COORD_BITS-1:0]    pixel_x,
    input  logic [COORD_BITS-1:0]    pixel_y,
    input  logic [23:0]              dest_pixel,
    input  logic [23:0]              pattern_pixel,
    input  logic                     mask_pass,
    output logic                     q_push,
    output rpbb_pkg::rpbb_entry_t    q_entry,
    input  logic                     q_full
);
    import rpbb_pkg::*;

    localparam int MAGW = ((COORD_BITS + 8 > 21) ? COORD_BITS + 8 : 21) + 1;
    localparam int DW   = MAGW + 1;
    localparam int SQW  = 2 * MAGW;
    localparam int SUMW = SQW + 1;

    logic [DW-1:0]   px_ext, py_ext, cx_ext, cy_ext, dx, dy;
    logic [MAGW-1:0] ax_next, ay_next;
    logic [MAGW-1:0] ax_reg, ay_reg;
    logic [SQW-1:0]  sqx_reg, sqy_reg;
    logic [SUMW-1:0] d2;
    rpbb_item_t      item1_reg, item2_reg;
    logic            v1_reg, v2_reg;
    logic            adv1, adv2;

    assign px_ext = {{(DW-COORD_BITS-8){1'b0}}, pixel_x, 8'h00};
    assign py_ext = {{(DW-COORD_BITS-8){1'b0}}, pixel_y, 8'h00};
    assign cx_ext = {{(DW-21){cfg.center_x[20]}}, cfg.center_x};
    assign cy_ext = {{(DW-21){cfg.center_y[20]}}, cfg.center_y};
    assign dx = px_ext - cx_ext;
    assign dy = py_ext - cy_ext;

    always_comb
    begin
        ax_next = dx[DW-1] ? MAGW'(-dx) : MAGW'(dx);
        ay_next = dy[DW-1] ? MAGW'(-dy) : MAGW'(dy);
    end

    assign adv2   = !v2_reg || !q_full;
    assign adv1   = !v1_reg || adv2;
    assign full   = !adv1;
    assign q_push = v2_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= push;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            item1_reg <= '{in_circle: 1'b0, mask: mask_pass, dest: dest_pixel,
                           pat: pattern_pixel};
        end
        if (adv2)
        begin
            sqx_reg   <= SQW'(ax_reg) * SQW'(ax_reg);
            sqy_reg   <= SQW'(ay_reg) * SQW'(ay_reg);
            item2_reg <= item1_reg;
        end
    end

    assign d2 = SUMW'(sqx_reg) + SUMW'(sqy_reg);

    always_comb
    begin
        q_entry                = '0;
        q_entry.item           = item2_reg;
        q_entry.item.in_circle = (d2 <= SUMW'(cfg.r2));
        q_entry.d2             = d2[D2_BITS-1:0];
    end

endmodule

// ===== rtl/core/rpbb_fifo.sv =====
// Four-entry queue between the front end and the back end.
// Uses rpbb_pkg for the entry type.
module rpbb_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rpbb_pkg::rpbb_entry_t wr_entry,
    output logic                  full,
    input  logic                  pop,
    output rpbb_pkg::rpbb_entry_t rd_entry,
    output logic                  empty
);
    import rpbb_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    rpbb_entry_t   mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [PW:0]   count_reg;

    assign full     = (count_reg == (PW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_entry;
    end

endmodule

// ===== rtl/core/rpbb_back.sv =====
// Back end: pipelined square root, pipelined divide, weight and channel blend,
// output register. Uses rpbb_pkg.
module rpbb_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rpbb_pkg::rpbb_back_cfg_t cfg,
    input  rpbb_pkg::rpbb_entry_t    q_entry,
    input  logic                     q_empty,
    output logic                     q_pop,
    output logic                     empty,
    input  logic                     pop,
    output logic                     write_enable,
    output logic [23:0]              new_pixel
);
    import rpbb_pkg::*;

    localparam int SQ_N = ROOT_BITS;
    localparam int DV_N = QUOT_BITS;
    localparam int RADW = 2 * ROOT_BITS;

    logic en;

    // square root stages, one result bit each
    logic                 sq_v_reg    [SQ_N];
    logic [31:0]          sq_rem_reg  [SQ_N];
    logic [31:0]          sq_rem_next [SQ_N];
    logic [ROOT_BITS-1:0] sq_root_reg [SQ_N];
    logic [ROOT_BITS-1:0] sq_root_next[SQ_N];
    logic [RADW-1:0]      sq_rad_reg  [SQ_N];
    logic [RADW-1:0]      sq_rad_next [SQ_N];
    rpbb_item_t           sq_item_reg [SQ_N];

    // divide stages, one quotient bit each
    logic                 dv_v_reg    [DV_N];
    logic [19:0]          dv_rem_reg  [DV_N];
    logic [19:0]          dv_rem_next [DV_N];
    logic [DV_N-1:0]      dv_num_reg  [DV_N];
    logic [DV_N-1:0]      dv_num_next [DV_N];
    logic [DV_N-1:0]      dv_q_reg    [DV_N];
    logic [DV_N-1:0]      dv_q_next   [DV_N];
    rpbb_item_t           dv_item_reg [DV_N];

    logic        b1_v_reg, b2_v_reg, out_v_reg;
    logic [16:0] s_reg;
    logic [15:0] c_reg [3];
    logic [23:0] b1_dest_reg;
    logic        b1_we_reg, b2_we_reg;
    logic [32:0] pc_reg [3];
    logic [24:0] pd_reg [3];
    logic        out_we_reg;
    logic [23:0] out_pix_reg;

    logic [16:0] ratio, att;
    logic [33:0] sprod;
    logic [16:0] s_next;
    logic [23:0] cprod [3];
    logic [15:0] c_next [3];
    logic [7:0]  pch [3];
    logic [15:0] gch [3];
    logic [7:0]  dch [3];
    logic [33:0] sum [3];

    assign en    = !out_v_reg || pop;
    assign q_pop = en && !q_empty;
    assign empty = !out_v_reg;

    always_comb
    begin
        logic [31:0]          rem_in;
        logic [ROOT_BITS-1:0] root_in;
        logic [RADW-1:0]      rad_in;
        logic [33:0]          t;
        logic [33:0]          trial;
        for (int k = 0; k < SQ_N; k++)
        begin
            if (k == 0)
            begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = {q_entry.d2, {(RADW-D2_BITS){1'b0}}};
            end
            else
            begin
                rem_in  = sq_rem_reg[k-1];
                root_in = sq_root_reg[k-1];
                rad_in  = sq_rad_reg[k-1];
            end
            t     = {rem_in, rad_in[RADW-1:RADW-2]};
            trial = {1'b0, root_in, 2'b01};
            if (t >= trial)
            begin
                sq_rem_next[k]  = 32'(t - trial);
                sq_root_next[k] = {root_in[ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k]  = t[31:0];
                sq_root_next[k] = {root_in[ROOT_BITS-2:0], 1'b0};
            end
            sq_rad_next[k] = {rad_in[RADW-3:0], 2'b00};
        end
    end

    always_comb
    begin
        logic [19:0]     rem_in;
        logic [DV_N-1:0] num_in;
        logic [DV_N-1:0] q_in;
        logic [35:0]     dividend;
        logic [20:0]     t;
        dividend = {sq_root_reg[SQ_N-1], 5'b00000};
        for (int j = 0; j < DV_N; j++)
        begin
            if (j == 0)
            begin
                rem_in = {1'b0, dividend[35:DV_N]};
                num_in = dividend[DV_N-1:0];
                q_in   = '0;
            end
            else
            begin
                rem_in = dv_rem_reg[j-1];
                num_in = dv_num_reg[j-1];
                q_in   = dv_q_reg[j-1];
            end
            t = {rem_in, num_in[DV_N-1]};
            if (t >= {1'b0, cfg.radius})
            begin
                dv_rem_next[j] = 20'(t - {1'b0, cfg.radius});
                dv_q_next[j]   = {q_in[DV_N-2:0], 1'b1};
            end
            else
            begin
                dv_rem_next[j] = t[19:0];
                dv_q_next[j]   = {q_in[DV_N-2:0], 1'b0};
            end
            dv_num_next[j] = {num_in[DV_N-2:0], 1'b0};
        end
    end

    // weight, gained pattern channels and blend sums
    always_comb
    begin
        ratio  = (dv_q_reg[DV_N-1] > FULL_ONE) ? FULL_ONE : dv_q_reg[DV_N-1];
        att    = FULL_ONE - ratio;
        sprod  = 34'(att) * 34'(cfg.hardness);
        s_next = (dv_item_reg[DV_N-1].in_circle && dv_item_reg[DV_N-1].mask)
                 ? sprod[32:16] : 17'd0;
        pch[0] = dv_item_reg[DV_N-1].pat[7:0];
        pch[1] = dv_item_reg[DV_N-1].pat[15:8];
        pch[2] = dv_item_reg[DV_N-1].pat[23:16];
        gch[0] = cfg.gain_r;
        gch[1] = cfg.gain_g;
        gch[2] = cfg.gain_b;
        for (int c = 0; c < 3; c++)
        begin
            cprod[c]  = 24'(pch[c]) * 24'(gch[c]);
            c_next[c] = (cprod[c] > 24'(CH_MAX_Q8)) ? CH_MAX_Q8 : cprod[c][15:0];
        end
        dch[0] = b1_dest_reg[23:16];
        dch[1] = b1_dest_reg[15:8];
        dch[2] = b1_dest_reg[7:0];
        for (int c = 0; c < 3; c++)
            sum[c] = 34'(pc_reg[c]) + {1'b0, pd_reg[c], 8'h00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQ_N; k++)
                sq_v_reg[k] <= 1'b0;
            for (int j = 0; j < DV_N; j++)
                dv_v_reg[j] <= 1'b0;
            b1_v_reg  <= 1'b0;
            b2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg[0] <= !q_empty;
            for (int k = 1; k < SQ_N; k++)
                sq_v_reg[k] <= sq_v_reg[k-1];
            dv_v_reg[0] <= sq_v_reg[SQ_N-1];
            for (int j = 1; j < DV_N; j++)
                dv_v_reg[j] <= dv_v_reg[j-1];
            b1_v_reg  <= dv_v_reg[DV_N-1];
            b2_v_reg  <= b1_v_reg;
            out_v_reg <= b2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQ_N; k++)
            begin
                sq_rem_reg[k]  <= sq_rem_next[k];
                sq_root_reg[k] <= sq_root_next[k];
                sq_rad_reg[k]  <= sq_rad_next[k];
            end
            sq_item_reg[0] <= q_entry.item;
            for (int k = 1; k < SQ_N; k++)
                sq_item_reg[k] <= sq_item_reg[k-1];
            for (int j = 0; j < DV_N; j++)
            begin
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_num_reg[j] <= dv_num_next[j];
                dv_q_reg[j]   <= dv_q_next[j];
            end
            dv_item_reg[0] <= sq_item_reg[SQ_N-1];
            for (int j = 1; j < DV_N; j++)
                dv_item_reg[j] <= dv_item_reg[j-1];

            s_reg       <= s_next;
            b1_dest_reg <= dv_item_reg[DV_N-1].dest;
            b1_we_reg   <= dv_item_reg[DV_N-1].in_circle;
            for (int c = 0; c < 3; c++)
                c_reg[c] <= c_next[c];

            b2_we_reg <= b1_we_reg;
            for (int c = 0; c < 3; c++)
            begin
                pc_reg[c] <= 33'(c_reg[c]) * 33'(s_reg);
                pd_reg[c] <= 25'(dch[c]) * 25'(FULL_ONE - s_reg);
            end

            out_we_reg  <= b2_we_reg;
            out_pix_reg <= {sum[0][31:24], sum[1][31:24], sum[2][31:24]};
        end
    end

    assign write_enable = out_we_reg;
    assign new_pixel    = out_pix_reg;

endmodule
